@@ sv/iptp_pkg.sv @@
package iptp_pkg;

    localparam logic [3:0] NO_ELISION = 4'd15;
    localparam logic [9:0] BAD_OCTET  = 10'd1023;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic       err;
        logic       scope;
        logic       colon;
        logic       quad;
        logic       prev_colon;
        logic       scope_digit;
    } t_flags;

    typedef struct packed {
        logic [7:0][15:0] groups;
        logic [3:0]       gcnt;
        logic [3:0]       elide;
        logic [15:0]      hex;
        logic [2:0]       hcnt;
        logic [9:0]       oct;
        logic [1:0]       ocnt;
        logic [3:0][7:0]  quad;
        logic [2:0]       qcnt;
        logic [31:0]      scope;
        t_flags           flags;
    } t_state;

    typedef struct packed {
        logic        valid_res;
        logic        is_v6;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [31:0] scope_val;
    } t_result;

    function automatic t_state reset_state();
        t_state s;
        s       = '0;
        s.elide = NO_ELISION;
        return s;
    endfunction

endpackage

@@ sv/iptp_step.sv @@
// Next parser state for one character, plus the finished result on the last one.
module iptp_step (
    input  iptp_pkg::t_state  i_state,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    output iptp_pkg::t_state  o_state,
    output iptp_pkg::t_result o_result
);

    iptp_pkg::t_state s;
    iptp_pkg::t_state f;
    logic       is_dig;
    logic [4:0] hv;
    logic       hex_ok;
    logic [35:0] sv10;
    logic [13:0] ov10;
    logic       oct_ok;
    logic [7:0][15:0] g;
    logic [3:0] t;
    logic [3:0] idx;

    function automatic logic grp_empty(iptp_pkg::t_state x);
        return x.hcnt == 3'd0 && x.ocnt == 2'd0 && !x.flags.quad;
    endfunction

    function automatic logic oct_good(iptp_pkg::t_state x);
        return x.ocnt != 2'd0 && x.oct <= 10'd255;
    endfunction

    function automatic iptp_pkg::t_state push(iptp_pkg::t_state x, logic [15:0] v);
        iptp_pkg::t_state y;
        y = x;
        if (x.gcnt >= 4'd8) begin
            y.flags.err = 1'b1;
        end else begin
            y.groups[x.gcnt[2:0]] = v;
            y.gcnt = x.gcnt + 4'd1;
        end
        return y;
    endfunction

    // address finish: close the trailing group or quad, then check group count
    function automatic iptp_pkg::t_state finish(iptp_pkg::t_state x);
        iptp_pkg::t_state y;
        y = x;
        if (!x.flags.colon) begin
            if (!x.flags.quad || x.qcnt != 3'd3 || !oct_good(x) || x.flags.scope)
                y.flags.err = 1'b1;
            else
                y.quad[3] = x.oct[7:0];
        end else begin
            if (grp_empty(x)) begin
                if (!(x.elide != iptp_pkg::NO_ELISION && x.elide == x.gcnt
                      && x.flags.prev_colon))
                    y.flags.err = 1'b1;
            end else if (x.flags.quad) begin
                if (x.qcnt != 3'd3 || !oct_good(x) || x.gcnt > 4'd6) begin
                    y.flags.err = 1'b1;
                end else begin
                    y.quad[3] = x.oct[7:0];
                    y = push(y, {x.quad[0], x.quad[1]});
                    y = push(y, {x.quad[2], x.oct[7:0]});
                end
            end else begin
                y = push(y, x.hex);
            end
            if (!y.flags.err) begin
                if (y.elide != iptp_pkg::NO_ELISION ? y.gcnt > 4'd7 : y.gcnt != 4'd8)
                    y.flags.err = 1'b1;
            end
        end
        return y;
    endfunction

    always_comb begin
        is_dig = i_char >= iptp_pkg::CH_ZERO && i_char <= iptp_pkg::CH_NINE;
        hex_ok = 1'b1;
        hv     = 5'd0;
        if (is_dig)                             hv = {1'b0, i_char[3:0]};
        else if (i_char >= 8'h61 && i_char <= 8'h66) hv = 5'(i_char - 8'h57);
        else if (i_char >= 8'h41 && i_char <= 8'h46) hv = 5'(i_char - 8'h37);
        else                                    hex_ok = 1'b0;
        sv10 = 36'(i_state.scope) * 36'd10 + 36'(i_char[3:0]);
        ov10 = 14'(i_state.oct) * 14'd10 + 14'(i_char[3:0]);
        oct_ok = 1'b0;

        s = i_state;
        if (!i_state.flags.err) begin
            if (i_state.flags.scope) begin
                if (!is_dig || sv10 > 36'hFFFFFFFF) begin
                    s.flags.err = 1'b1;
                end else begin
                    s.scope = sv10[31:0];
                    s.flags.scope_digit = 1'b1;
                end
            end else if (i_char == iptp_pkg::CH_COLON) begin
                if (i_state.flags.quad) begin
                    s.flags.err = 1'b1;
                end else if (i_state.flags.prev_colon) begin
                    if (i_state.elide != iptp_pkg::NO_ELISION) s.flags.err = 1'b1;
                    else s.elide = i_state.gcnt;
                end else if (grp_empty(i_state)) begin
                    if (i_state.gcnt != 4'd0 || i_state.flags.colon) s.flags.err = 1'b1;
                end else begin
                    s = push(i_state, i_state.hex);
                    s.hex = '0; s.hcnt = '0; s.oct = '0; s.ocnt = '0;
                    s.flags.quad = 1'b0;
                end
                if (!s.flags.err) begin
                    s.flags.colon = 1'b1;
                    s.flags.prev_colon = 1'b1;
                end
            end else if (i_state.flags.prev_colon && i_state.gcnt == 4'd0
                         && i_state.elide == iptp_pkg::NO_ELISION) begin
                s.flags.err = 1'b1;
            end else begin
                s.flags.prev_colon = 1'b0;
                if (i_char == iptp_pkg::CH_PCT) begin
                    s.flags.scope = 1'b1;
                    s = finish(s);
                end else if (i_char == iptp_pkg::CH_DOT) begin
                    if (!oct_good(i_state) || i_state.qcnt >= 3'd3) begin
                        s.flags.err = 1'b1;
                    end else begin
                        s.quad[i_state.qcnt[1:0]] = i_state.oct[7:0];
                        s.qcnt = i_state.qcnt + 3'd1;
                        s.oct  = '0;
                        s.ocnt = '0;
                        s.flags.quad = 1'b1;
                    end
                end else if (!hex_ok) begin
                    s.flags.err = 1'b1;
                end else if (!i_state.flags.quad && i_state.hcnt >= 3'd4) begin
                    s.flags.err = 1'b1;
                end else if (i_state.flags.quad && !is_dig) begin
                    s.flags.err = 1'b1;
                end else begin
                    if (!i_state.flags.quad) begin
                        s.hex  = {i_state.hex[11:0], hv[3:0]};
                        s.hcnt = i_state.hcnt + 3'd1;
                    end
                    oct_ok = is_dig && i_state.ocnt != 2'd3
                          && !(i_state.ocnt == 2'd1 && i_state.oct == 10'd0);
                    if (!oct_ok || ov10 > 14'd255) s.oct = iptp_pkg::BAD_OCTET;
                    else s.oct = ov10[9:0];
                    if (i_state.ocnt != 2'd3) s.ocnt = i_state.ocnt + 2'd1;
                end
            end
        end

        f = s;
        if (!s.flags.err) begin
            if (!s.flags.scope) f = finish(s);
            else if (!s.flags.scope_digit) f.flags.err = 1'b1;
        end

        // expand the elision into the final eight groups
        g   = '0;
        idx = '0;
        t   = f.gcnt - f.elide;
        for (int i = 0; i < 8; i++) begin
            if (f.elide == iptp_pkg::NO_ELISION) begin
                if (4'(i) < f.gcnt) g[i] = f.groups[i];
            end else if (4'(i) < f.elide) begin
                g[i] = f.groups[i];
            end else begin
                idx = 4'(i) + t - 4'd8 + f.elide;
                if (4'(i) >= 4'd8 - t && idx < 4'd8) g[i] = f.groups[idx[2:0]];
            end
        end

        o_result = '0;
        if (!f.flags.err) begin
            o_result.valid_res = 1'b1;
            if (!f.flags.colon) begin
                o_result.address_low = {32'd0, f.quad[0], f.quad[1], f.quad[2], f.quad[3]};
            end else begin
                o_result.is_v6        = 1'b1;
                o_result.address_high = {g[0], g[1], g[2], g[3]};
                o_result.address_low  = {g[4], g[5], g[6], g[7]};
                o_result.scope_val    = f.scope;
            end
        end

        o_state = i_last ? iptp_pkg::reset_state() : s;
    end

endmodule

@@ sv/ip_address_text_parser_unit.sv @@
// Channel | Dir | tdata fields (low bit up)                          | tuser
// s_axis  | in  | character[7:0]                                     | -
// m_axis  | out | valid_res, is_v6, address_high, address_low,       | -
//         |     | scope_val, 6 zero fill bits (168 bits)             |
// One character per cycle while the skid slot is empty; state updates in the same cycle it is accepted.
// The result enters the output register at the edge that accepts the last
// character if that register is free, else a second output slot (skid), which
// keeps input flowing while stalled.
// Input stalls only when both output slots are full.
// Reset clears the parse state and empties both output slots.
module ip_address_text_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // character[7:0]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata    // valid_res, is_v6, addr_hi, addr_lo, scope
);

    iptp_pkg::t_state  r_state, n_state;
    iptp_pkg::t_result w_res;
    iptp_pkg::t_result r_out, r_skid;
    logic r_out_v, r_skid_v;
    logic w_acc, w_push;

    iptp_step u_step (
        .i_state  (r_state),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_state  (n_state),
        .o_result (w_res)
    );

    assign s_axis_tready = !r_skid_v;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_push = w_acc && s_axis_tlast;

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {6'd0, r_out.scope_val, r_out.address_low, r_out.address_high,
                            r_out.is_v6, r_out.valid_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iptp_pkg::reset_state();
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_acc) r_state <= n_state;
            if (!r_out_v || m_axis_tready) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out   <= w_res;
                    r_out_v <= w_push;
                end
            end else if (w_push) begin
                r_skid   <= w_res;
                r_skid_v <= 1'b1;
            end
        end
    end

endmodule

@@ sv/iptp_checker.sv @@
module iptp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [167:0] m_axis_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[167:1] == '0)
        else $error("invalid result not all zero");

    a_v4_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[1]
        |-> m_axis_tdata[65:2] == '0 && m_axis_tdata[129:98] == '0
            && m_axis_tdata[161:130] == '0)
        else $error("IPv4 result has stray bits");

    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("input still blocked after result taken");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind ip_address_text_parser_unit iptp_checker u_iptp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
